// File: rtl/bvfd_pkg.sv
// Package for the binary velocity frame deframer.
// Frame constants, cell expectations and the parser state type. No dependencies.

package bvfd_pkg;

    localparam int FRAME_LEN  = 12;
    // Byte 0 is the start byte and byte 11 is unused, so cells hold bytes 1 to 10
    localparam int CELL_COUNT = FRAME_LEN - 2;
    localparam int CNT_W      = $clog2(FRAME_LEN);

    localparam logic [CNT_W-1:0] CNT_START = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(FRAME_LEN - 1);

    localparam logic [7:0] START_BYTE = 8'hAA;
    localparam logic [7:0] HDR1       = 8'hBB;
    localparam logic [7:0] HDR2       = 8'h0A;
    localparam logic [7:0] HDR3       = 8'h12;
    localparam logic [7:0] HDR4       = 8'h02;

    localparam logic FUNC_BYTE  = 1'b0;
    localparam logic FUNC_FLUSH = 1'b1;

    // Cell 0 holds the newest byte; at frame end cell k holds byte 10-k
    localparam logic [7:0] CELL_EXPECT [CELL_COUNT] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, HDR4, HDR3, HDR2, HDR1
    };
    localparam logic [CELL_COUNT-1:0] CELL_CHECK = CELL_COUNT'(10'b11_1100_0000);

    typedef enum logic {
        ST_IDLE,
        ST_COLLECT
    } bvfd_state_t;

endpackage

// File: rtl/bvfd_cell.sv
// One byte cell of the frame shift chain.
// Holds a byte, hands it on to the next cell and flags a match against a header byte.
// Depends on bvfd_pkg.

module bvfd_cell
    import bvfd_pkg::*;
(
    input  logic       aclk,
    input  logic       shift_en,
    input  logic [7:0] byte_in,
    input  logic [7:0] expect_byte,
    output logic [7:0] byte_out,
    output logic       match
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    always_comb begin
        byte_next = shift_en ? byte_in : byte_reg;
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
    end

    assign byte_out = byte_reg;
    assign match    = (byte_reg == expect_byte);

endmodule

// File: rtl/binary_velocity_frame_deframer.sv
// Top level of the binary velocity frame deframer.
// Parser control, a chain of bvfd_cell byte cells and the result register.
// Depends on bvfd_pkg and bvfd_cell.
//
//  channel | ports        | tdata (low bit up)                     | tuser
//  --------+--------------+----------------------------------------+----------------------
//  input   | s_t*         | rx_byte[7:0]                           | func (0 byte, 1 flush)
//  result  | m_t*         | vel_x[15:0], vel_y[31:16], yaw[47:32]  | -
//
// One input item per cycle while s_tready is high; a result appears on m_* the cycle
// after the twelfth byte of a good frame is taken. Bytes 1 to 10 shift the cell chain.
// aresetn (synchronous, active low) returns the parser to idle and empties the result
// register; the byte cells are not reset, every byte is written before it is used.
// s_tready drops only while a result waits and m_tready is low.

module binary_velocity_frame_deframer
    import bvfd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] func
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // [15:0] vel_x, [31:16] vel_y, [47:32] yaw_rate
);

    bvfd_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [47:0]       m_tdata_reg, m_tdata_next;

    logic              s_accept;
    logic              is_flush;
    logic              shift_en;
    logic              frame_end;
    logic              emit;
    logic              header_ok;

    logic [7:0]            cell_q     [CELL_COUNT];
    logic [CELL_COUNT-1:0] cell_match;

    // Ready whenever the result register is free or being emptied this cycle
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign is_flush = (s_tuser == FUNC_FLUSH);

    // Byte chain: cell 0 takes the incoming byte, each cell feeds the next
    for (genvar k = 0; k < CELL_COUNT; k++) begin : g_cell
        bvfd_cell u_cell (
            .aclk        (aclk),
            .shift_en    (shift_en),
            .byte_in     ((k == 0) ? s_tdata : cell_q[(k == 0) ? 0 : k - 1]),
            .expect_byte (CELL_EXPECT[k]),
            .byte_out    (cell_q[k]),
            .match       (cell_match[k])
        );
    end

    // Start byte is known on entry; only bytes 1 to 4 need checking
    assign header_ok = &(cell_match | ~CELL_CHECK);

    // Next-state logic
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        if (s_accept) begin
            if (is_flush) begin
                state_next = ST_IDLE;
                count_next = '0;
            end else begin
                unique case (state_reg)
                    ST_IDLE: begin
                        if (s_tdata == START_BYTE) begin
                            state_next = ST_COLLECT;
                            count_next = CNT_START;
                        end
                    end
                    ST_COLLECT: begin
                        if (count_reg == CNT_LAST) begin
                            state_next = ST_IDLE;
                            count_next = '0;
                        end else begin
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    default: begin
                        state_next = ST_IDLE;
                        count_next = '0;
                    end
                endcase
            end
        end
    end

    // Output logic of the parser
    always_comb begin
        shift_en  = 1'b0;
        frame_end = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                shift_en  = 1'b0;
                frame_end = 1'b0;
            end
            ST_COLLECT: begin
                shift_en  = s_accept && !is_flush && (count_reg != CNT_LAST);
                frame_end = s_accept && !is_flush && (count_reg == CNT_LAST);
            end
            default: begin
                shift_en  = 1'b0;
                frame_end = 1'b0;
            end
        endcase
    end

    assign emit = frame_end && header_ok;

    // Result register: little-endian pairs, cell 4/5 = bytes 6/5 and so on
    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        if (emit) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {cell_q[0], cell_q[1], cell_q[2], cell_q[3],
                             cell_q[4], cell_q[5]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Checks
    a_idle_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> count_reg == '0)
        else $error("count not clear while idle");

    a_collect_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_COLLECT |-> (count_reg != '0) && (count_reg <= CNT_LAST))
        else $error("count out of range while collecting");

    a_emit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> m_tvalid)
        else $error("good frame did not raise m_tvalid");

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> (!m_tvalid_reg || m_tready))
        else $error("result overwrote a waiting item");

endmodule
